// File: rtl/core/kwm_pkg.sv
// Package for the keypoint window median core: default sizes, register
// indexes, register widths and reset values. No dependencies.
`timescale 1ns / 1ps

package kwm_pkg;

	// Default sizes handed to the top level parameters.
	localparam int MAX_WINDOW_DEF    = 7;
	localparam int MAX_KEYPOINTS_DEF = 32;
	localparam int COORD_BITS_DEF    = 24;

	// Configuration port shape.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 6;

	// Register widths as seen by software.
	localparam int WINDOW_REG_W = 3;
	localparam int KPF_REG_W    = 6;

	// Register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_SIZE   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_KEYPOINTS_PER = 2'd1;

	// Register reset values.
	localparam logic [WINDOW_REG_W-1:0] WINDOW_RESET = 3'd3;
	localparam logic [KPF_REG_W-1:0]    KPF_RESET    = 6'd17;

endpackage

// File: rtl/core/keypoint_window_median_core.sv
// Keypoint window median core: history memory, insertion sorter and sequencer.
// Depends on kwm_pkg for default sizes, register indexes and reset values.
`timescale 1ns / 1ps

// Usage
// Keypoints enter on the coord channel (coord_valid, coord_stall, coord_x,
// coord_y) one transfer per keypoint, frame after frame. Each keypoint yields
// exactly one result transfer on the smooth channel (smooth_valid,
// smooth_stall, smooth_x, smooth_y, frame_last, filtered).
// With an effective window of W frames, a filtered item runs through these
// steps from one input transfer to the next: W-1 reads of stored history
// through the single read port of the history memory, a drain step for the
// read latency, a finish step that writes the current keypoint back and
// loads the result, and an idle step in which the next transfer is taken.
// An item that is passed through unfiltered, or filtered with a one-frame
// window, goes straight from its transfer to the finish step and then back
// to idle. coord_stall is high while an item is at work.
// Reset (arst_n low) restores window_size 3 and keypoints_per_frame 17 and
// empties the window; the history memory is not cleared, since the fill rule
// never reads an entry before it has been written. A write to either
// register restarts the fill in the same way.
// When the receiver stalls, the finished result waits in the output register
// and the next input transfer may still be taken; that item then waits in
// its final step until the output register frees up.
module keypoint_window_median_core #(
	parameter int MAX_WINDOW    = kwm_pkg::MAX_WINDOW_DEF,
	parameter int MAX_KEYPOINTS = kwm_pkg::MAX_KEYPOINTS_DEF,
	parameter int COORD_BITS    = kwm_pkg::COORD_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Configuration write port.
	input  logic                               cfg_write,
	input  logic [kwm_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [kwm_pkg::CFG_DATA_W-1:0]     cfg_data,
	// Input channel.
	input  logic                               coord_valid,
	output logic                               coord_stall,
	input  logic signed [COORD_BITS-1:0]       coord_x,
	input  logic signed [COORD_BITS-1:0]       coord_y,
	// Result channel.
	output logic                               smooth_valid,
	input  logic                               smooth_stall,
	output logic signed [COORD_BITS-1:0]       smooth_x,
	output logic signed [COORD_BITS-1:0]       smooth_y,
	output logic                               frame_last,
	output logic                               filtered
);

	// Width of values 0..MAX_WINDOW (window length, depth, rank, fill count).
	localparam int WIN_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW + 1) : 1;
	// Index into the sorted lists.
	localparam int LIDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	// Ring slot of the history memory, 0..MAX_WINDOW-2.
	localparam int SLOT_W  = (MAX_WINDOW > 2) ? $clog2(MAX_WINDOW - 1) : 1;
	// Keypoint position and keypoint count.
	localparam int POS_W   = (MAX_KEYPOINTS > 1) ? $clog2(MAX_KEYPOINTS) : 1;
	localparam int CNT_W   = $clog2(MAX_KEYPOINTS + 1);
	// Compare widths for register values against the maxima.
	localparam int WCMP_W  = (WIN_W > kwm_pkg::WINDOW_REG_W) ? WIN_W : kwm_pkg::WINDOW_REG_W;
	localparam int KCMP_W  = (CNT_W > kwm_pkg::KPF_REG_W) ? CNT_W : kwm_pkg::KPF_REG_W;
	// History memory: one row of keypoints per stored frame, x and y together.
	localparam int SLOTS     = (MAX_WINDOW > 1) ? (MAX_WINDOW - 1) : 1;
	localparam int MEM_DEPTH = SLOTS * MAX_KEYPOINTS;
	localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam int MW        = 2 * COORD_BITS;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_READ   = 4'b0010,
		S_DRAIN  = 4'b0100,
		S_FINISH = 4'b1000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [kwm_pkg::WINDOW_REG_W-1:0] window_size_q;
	logic [kwm_pkg::KPF_REG_W-1:0]    kpf_q;

	// Frame bookkeeping.
	logic [WIN_W-1:0]  frames_seen_q;
	logic [SLOT_W-1:0] frame_slot_q;
	logic [POS_W-1:0]  position_q;

	// Per-item context captured at the input transfer.
	logic signed [COORD_BITS-1:0] x_q, y_q;
	logic [POS_W-1:0]  item_pos_q;
	logic [SLOT_W-1:0] wr_slot_q;
	logic              wr_ok_q;
	logic              filt_q;
	logic              last_q;
	logic [WIN_W-1:0]  depth_q;
	logic [WIN_W-1:0]  rank_q;

	// Read sequencing and the sorted window lists.
	logic [SLOT_W-1:0] rd_cnt_q;
	logic              rd_vld_q;
	logic [MW-1:0]     rd_data_q;
	logic [WIN_W-1:0]  n_q;
	logic signed [COORD_BITS-1:0] xl_q [MAX_WINDOW];
	logic signed [COORD_BITS-1:0] yl_q [MAX_WINDOW];

	// Output register.
	logic                          out_valid_q;
	logic signed [COORD_BITS-1:0]  out_x_q, out_y_q;
	logic                          out_last_q, out_filt_q;

	logic [MW-1:0] mem [MEM_DEPTH];

	// Effective register values and the next bookkeeping state.
	logic [WIN_W-1:0]  w_eff, depth, rank;
	logic [CNT_W-1:0]  k_eff;
	logic [POS_W-1:0]  pos_eff, pos_next;
	logic              last, filt, wr_ok;
	logic [SLOT_W-1:0] slot_next;
	logic [WIN_W-1:0]  frames_next;
	logic              accept, finish_go, cfg_restart;
	logic              mem_we, mem_re;
	logic [AW-1:0]     wr_addr, rd_addr;

	always_comb begin
		if (window_size_q == '0) begin
			w_eff = WIN_W'(1);
		end else if (WCMP_W'(window_size_q) > WCMP_W'(MAX_WINDOW)) begin
			w_eff = WIN_W'(MAX_WINDOW);
		end else begin
			w_eff = WIN_W'(window_size_q);
		end
		if (kpf_q == '0) begin
			k_eff = CNT_W'(1);
		end else if (KCMP_W'(kpf_q) > KCMP_W'(MAX_KEYPOINTS)) begin
			k_eff = CNT_W'(MAX_KEYPOINTS);
		end else begin
			k_eff = CNT_W'(kpf_q);
		end
		depth   = w_eff - WIN_W'(1);
		rank    = w_eff >> 1;
		filt    = (frames_seen_q >= depth);
		pos_eff = (CNT_W'(position_q) >= k_eff) ? '0 : position_q;
		last    = ((CNT_W'(pos_eff) + CNT_W'(1)) >= k_eff);
		pos_next = last ? '0 : (pos_eff + POS_W'(1));
		wr_ok   = (depth != '0) && (WIN_W'(frame_slot_q) < depth);
		slot_next   = frame_slot_q;
		frames_next = frames_seen_q;
		if (last) begin
			if (depth != '0) begin
				slot_next   = ((WIN_W'(frame_slot_q) + WIN_W'(1)) >= depth) ?
				              '0 : (frame_slot_q + SLOT_W'(1));
				frames_next = (frames_seen_q < depth) ?
				              (frames_seen_q + WIN_W'(1)) : frames_seen_q;
			end else begin
				slot_next   = '0;
				frames_next = '0;
			end
		end
	end

	assign coord_stall = (state_q != S_IDLE);
	assign accept      = coord_valid && (state_q == S_IDLE);
	assign finish_go   = (state_q == S_FINISH) && (!out_valid_q || !smooth_stall);
	assign cfg_restart = cfg_write &&
	                     ((cfg_index == kwm_pkg::REG_WINDOW_SIZE) ||
	                      (cfg_index == kwm_pkg::REG_KEYPOINTS_PER));

	// Row address: slot times the row length plus keypoint position.
	assign mem_we  = finish_go && wr_ok_q;
	assign mem_re  = (state_q == S_READ);
	assign wr_addr = AW'(wr_slot_q) * AW'(MAX_KEYPOINTS) + AW'(item_pos_q);
	assign rd_addr = AW'(rd_cnt_q) * AW'(MAX_KEYPOINTS) + AW'(item_pos_q);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= {x_q, y_q};
		end
		if (mem_re) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Insertion unit: one history value a cycle goes into each sorted list.
	// Bit j+1 of gt_x flags list entry j as larger than the new value.
	logic signed [COORD_BITS-1:0] ins_x, ins_y;
	logic [MAX_WINDOW:0]          gt_x, gt_y;
	logic signed [COORD_BITS-1:0] xl_next [MAX_WINDOW];
	logic signed [COORD_BITS-1:0] yl_next [MAX_WINDOW];

	assign ins_x = rd_data_q[MW-1:COORD_BITS];
	assign ins_y = rd_data_q[COORD_BITS-1:0];

	always_comb begin
		gt_x[0] = 1'b0;
		gt_y[0] = 1'b0;
		for (int j = 0; j < MAX_WINDOW; j++) begin
			gt_x[j+1] = (WIN_W'(j) < n_q) && (xl_q[j] > ins_x);
			gt_y[j+1] = (WIN_W'(j) < n_q) && (yl_q[j] > ins_y);
		end
		for (int j = 0; j < MAX_WINDOW; j++) begin
			if (gt_x[j]) begin
				xl_next[j] = xl_q[j-1 < 0 ? 0 : j-1];
			end else if (gt_x[j+1] || (WIN_W'(j) == n_q)) begin
				xl_next[j] = ins_x;
			end else begin
				xl_next[j] = xl_q[j];
			end
			if (gt_y[j]) begin
				yl_next[j] = yl_q[j-1 < 0 ? 0 : j-1];
			end else if (gt_y[j+1] || (WIN_W'(j) == n_q)) begin
				yl_next[j] = ins_y;
			end else begin
				yl_next[j] = yl_q[j];
			end
		end
	end

	// Sorted lists: the current keypoint seeds them, history values follow.
	always_ff @(posedge clk) begin
		if (accept) begin
			xl_q[0] <= coord_x;
			yl_q[0] <= coord_y;
		end else if (rd_vld_q) begin
			xl_q <= xl_next;
			yl_q <= yl_next;
		end
	end

	// Item context and output payload. An item that is not filtered leaves
	// with the coordinates it came in with.
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q        <= coord_x;
			y_q        <= coord_y;
			item_pos_q <= pos_eff;
			wr_slot_q  <= frame_slot_q;
			wr_ok_q    <= wr_ok;
			filt_q     <= filt;
			last_q     <= last;
			depth_q    <= depth;
			rank_q     <= rank;
		end
		if (finish_go) begin
			out_x_q    <= filt_q ? xl_q[rank_q[LIDX_W-1:0]] : x_q;
			out_y_q    <= filt_q ? yl_q[rank_q[LIDX_W-1:0]] : y_q;
			out_last_q <= last_q;
			out_filt_q <= filt_q;
		end
	end

	// Sequencer, registers and bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			window_size_q <= kwm_pkg::WINDOW_RESET;
			kpf_q         <= kwm_pkg::KPF_RESET;
			frames_seen_q <= '0;
			frame_slot_q  <= '0;
			position_q    <= '0;
			rd_cnt_q      <= '0;
			rd_vld_q      <= 1'b0;
			n_q           <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			rd_vld_q <= mem_re;
			if (accept) begin
				n_q <= WIN_W'(1);
			end else if (rd_vld_q) begin
				n_q <= n_q + WIN_W'(1);
			end

			// Configuration writes restart the fill and win over bookkeeping.
			if (cfg_write && (cfg_index == kwm_pkg::REG_WINDOW_SIZE)) begin
				window_size_q <= cfg_data[kwm_pkg::WINDOW_REG_W-1:0];
			end
			if (cfg_write && (cfg_index == kwm_pkg::REG_KEYPOINTS_PER)) begin
				kpf_q <= cfg_data[kwm_pkg::KPF_REG_W-1:0];
			end
			if (cfg_restart) begin
				frames_seen_q <= '0;
				frame_slot_q  <= '0;
				position_q    <= '0;
			end else if (accept) begin
				frames_seen_q <= frames_next;
				frame_slot_q  <= slot_next;
				position_q    <= pos_next;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						rd_cnt_q <= '0;
						state_q  <= (filt && (depth != '0)) ? S_READ : S_FINISH;
					end
				end
				S_READ: begin
					rd_cnt_q <= rd_cnt_q + SLOT_W'(1);
					if ((WIN_W'(rd_cnt_q) + WIN_W'(1)) >= depth_q) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (finish_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (finish_go) begin
				out_valid_q <= 1'b1;
			end else if (!smooth_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign smooth_valid = out_valid_q;
	assign smooth_x     = out_x_q;
	assign smooth_y     = out_y_q;
	assign frame_last   = out_last_q;
	assign filtered     = out_filt_q;

`ifndef SYNTHESIS
	// After an input transfer the block is busy with that item.
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(coord_valid && !coord_stall) |=> coord_stall)
		else $error("input taken again right after a transfer");

	// The sorted lists never hold more than the window of the current item.
	a_list_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (n_q <= depth_q + WIN_W'(1)))
		else $error("sorted list overflow");

	// History is read only for items that are filtered with stored frames.
	a_read_only_filtered: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |-> (filt_q && (depth_q != '0)))
		else $error("history read for an unfiltered item");

	// A result is loaded only when the output register is free or drains.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(smooth_valid && smooth_stall) |=> ($stable(smooth_x) && $stable(smooth_y)))
		else $error("stalled result overwritten");
`endif

endmodule

// File: test/keypoint_window_median_core_test.sv
// Self-checking testbench for keypoint_window_median_core: directed and random
// keypoint traffic checked against a sliding-window median predictor.
// Depends on kwm_pkg and the core RTL only.
`timescale 1ns / 1ps

module keypoint_window_median_core_test;

	localparam int CW   = kwm_pkg::COORD_BITS_DEF;
	localparam int MAXW = kwm_pkg::MAX_WINDOW_DEF;
	localparam int MAXK = kwm_pkg::MAX_KEYPOINTS_DEF;

	// Half of the 12 ns clock period.
	localparam realtime HALF_PERIOD = 6ns;
	localparam int RESET_CYCLES = 7;
	// Cycles allowed after the last result before the registers are touched.
	// Every keypoint yields a result, so the core is idle by then; this is margin.
	localparam int SETTLE_CYCLES = 4;
	// A filtered keypoint keeps the core busy only while it works through its
	// window, and the receiver stalls at most 86 percent of the time, so a long
	// stretch with no transfer at all means the core has hung.
	localparam int QUIET_LIMIT = 2000;
	localparam int REPORT_LIMIT = 10;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic [kwm_pkg::CFG_INDEX_W-1:0] cfg_index_t;
	typedef logic [kwm_pkg::CFG_DATA_W-1:0] cfg_word_t;
	typedef coord_t window_t [MAXW];

	typedef struct packed {
		coord_t x;
		coord_t y;
		logic   last;
		logic   filt;
	} smooth_item_t;

	// Register indexes with no register behind them; the core must ignore them.
	localparam cfg_index_t REG_SPARE_A = 2'd2;
	localparam cfg_index_t REG_SPARE_B = 2'd3;

	localparam coord_t COORD_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(CW-1){1'b0}}};

	// DUT connections; every input has a known value from time zero.
	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_write = 1'b0;
	cfg_index_t cfg_index = '0;
	cfg_word_t  cfg_data = '0;
	logic       coord_valid = 1'b0;
	logic       coord_stall;
	coord_t     coord_x = '0;
	coord_t     coord_y = '0;
	logic       smooth_valid;
	logic       smooth_stall = 1'b0;
	coord_t     smooth_x;
	coord_t     smooth_y;
	logic       frame_last;
	logic       filtered;

	// Idle rates in percent: the sender leaves gaps between keypoints, the
	// receiver holds smooth_stall high.
	int send_idle_pct = 12;
	int stall_pct = 86;

	// Predictor state: register copies and the per-position frame history.
	logic [kwm_pkg::WINDOW_REG_W-1:0] win_reg = kwm_pkg::WINDOW_RESET;
	logic [kwm_pkg::KPF_REG_W-1:0]    kpf_reg = kwm_pkg::KPF_RESET;
	logic [2:0]              frames_seen = '0;
	logic [2:0]              frame_slot = '0;
	logic [4:0]              kp_pos = '0;
	coord_t                  hist_x [MAXW][MAXK] = '{default: '0};
	coord_t                  hist_y [MAXW][MAXK] = '{default: '0};

	// Results predicted for keypoints already transferred, oldest first.
	smooth_item_t pending_smooth[$];
	int fault_count = 0;
	int quiet_cycles = 0;

	keypoint_window_median_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.coord_valid  (coord_valid),
		.coord_stall  (coord_stall),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.smooth_valid (smooth_valid),
		.smooth_stall (smooth_stall),
		.smooth_x     (smooth_x),
		.smooth_y     (smooth_y),
		.frame_last   (frame_last),
		.filtered     (filtered)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// The receiver decides each cycle whether to stall the result channel.
	always @(posedge clk) begin
		smooth_stall <= ($urandom_range(99) < stall_pct);
	end

	// Effective window length: zero counts as one frame.
	function automatic int window_frames();
		if (win_reg == 0)
			return 1;
		return (int'(win_reg) > MAXW) ? MAXW : int'(win_reg);
	endfunction

	// Effective keypoints per frame: zero counts as one, large values clamp.
	function automatic int frame_keypoints();
		if (kpf_reg == 0)
			return 1;
		return (int'(kpf_reg) > MAXK) ? MAXK : int'(kpf_reg);
	endfunction

	// Value at the given ascending rank among the first n entries (signed).
	function automatic coord_t rank_value(input window_t vals, input int n, input int rank);
		coord_t t;
		int i;
		int j;
		for (i = 1; i < n; i++) begin
			t = vals[i];
			j = i;
			while (j > 0 && vals[j-1] > t) begin
				vals[j] = vals[j-1];
				j--;
			end
			vals[j] = t;
		end
		return vals[rank];
	endfunction

	// Predicts the result of one keypoint and advances the window state.
	function automatic smooth_item_t smooth_keypoint(input coord_t x, input coord_t y);
		int w;
		int k;
		int depth;
		int pos;
		int s;
		window_t wx;
		window_t wy;
		smooth_item_t r;
		w = window_frames();
		k = frame_keypoints();
		depth = w - 1;
		pos = int'(kp_pos);
		if (pos >= k)
			pos = 0;
		r.x = x;
		r.y = y;
		r.filt = (int'(frames_seen) >= depth);
		r.last = (pos + 1 >= k);
		// Once depth earlier frames are stored, each axis takes the median
		// of those frames plus the current one at this keypoint position.
		if (r.filt) begin
			for (s = 0; s < depth; s++) begin
				wx[s] = hist_x[s][pos];
				wy[s] = hist_y[s][pos];
			end
			wx[depth] = x;
			wy[depth] = y;
			r.x = rank_value(wx, w, w / 2);
			r.y = rank_value(wy, w, w / 2);
		end
		if (depth > 0 && int'(frame_slot) < depth) begin
			hist_x[frame_slot][pos] = x;
			hist_y[frame_slot][pos] = y;
		end
		if (r.last) begin
			kp_pos = '0;
			if (depth > 0) begin
				frame_slot = (int'(frame_slot) + 1 >= depth) ? 3'd0 : frame_slot + 3'd1;
				if (int'(frames_seen) < depth)
					frames_seen = frames_seen + 3'd1;
			end else begin
				frame_slot = '0;
				frames_seen = '0;
			end
		end else begin
			kp_pos = 5'(pos + 1);
		end
		return r;
	endfunction

	// Coordinates: full random words, values near zero so that medians see
	// ties, and the extremes of the signed range.
	function automatic coord_t random_coord();
		int near_zero;
		near_zero = int'($urandom_range(8)) - 4;
		case ($urandom_range(3))
			0: return coord_t'(near_zero);
			1: begin
				case ($urandom_range(3))
					0: return COORD_MIN;
					1: return COORD_MAX;
					2: return '0;
					default: return '1;
				endcase
			end
			default: return coord_t'($urandom);
		endcase
	endfunction

	// Keypoint count data: mostly small frames, sometimes large ones, and now
	// and then zero or a value past the maximum.
	function automatic cfg_word_t random_count_data();
		int pick;
		pick = int'($urandom_range(9));
		if (pick < 7)
			return cfg_word_t'($urandom_range(8, 1));
		if (pick < 9)
			return cfg_word_t'($urandom_range(32, 9));
		return ($urandom_range(1) == 0) ? cfg_word_t'(0) : cfg_word_t'($urandom_range(63, 33));
	endfunction

	// Writes one register and mirrors it in the predictor. The core is idle
	// whenever this is called, so the restart applies between keypoints.
	task automatic write_register(input cfg_index_t idx, input cfg_word_t data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (idx == kwm_pkg::REG_WINDOW_SIZE) begin
			win_reg = data[kwm_pkg::WINDOW_REG_W-1:0];
			frames_seen = '0;
			frame_slot = '0;
			kp_pos = '0;
		end else if (idx == kwm_pkg::REG_KEYPOINTS_PER) begin
			kpf_reg = data[kwm_pkg::KPF_REG_W-1:0];
			frames_seen = '0;
			frame_slot = '0;
			kp_pos = '0;
		end
		@(posedge clk);
	endtask

	// Sends one keypoint, possibly after a random gap. Valid stays high after
	// the transfer so back-to-back keypoints need not drop it in between;
	// settle_block drops it at the end of a batch.
	task automatic send_keypoint(input coord_t x, input coord_t y);
		logic taken;
		if ($urandom_range(99) < send_idle_pct) begin
			coord_valid <= 1'b0;
			coord_x <= coord_t'($urandom);
			coord_y <= coord_t'($urandom);
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		coord_valid <= 1'b1;
		coord_x <= x;
		coord_y <= y;
		// Stall is sampled at the falling edge, where it is stable; the
		// transfer itself happens at the next rising edge.
		do begin
			@(negedge clk);
			taken = !coord_stall;
			@(posedge clk);
		end while (!taken);
		pending_smooth.push_back(smooth_keypoint(x, y));
	endtask

	// Stops the input channel and waits until every predicted result is in.
	task automatic settle_block();
		coord_valid <= 1'b0;
		while (pending_smooth.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Reset values: window of 3 frames over 17 keypoints, so the third frame
	// is the first filtered one.
	task automatic test_reset_values();
		int i;
		for (i = 0; i < 17 * 3 + 5; i++)
			send_keypoint(random_coord(), random_coord());
		settle_block();
	endtask

	// A window size of zero acts as one frame: every keypoint is filtered and
	// comes back as itself, extremes included.
	task automatic test_window_one_extremes();
		write_register(kwm_pkg::REG_WINDOW_SIZE, cfg_word_t'(0));
		write_register(kwm_pkg::REG_KEYPOINTS_PER, cfg_word_t'(1));
		send_keypoint(COORD_MIN, COORD_MAX);
		send_keypoint(COORD_MAX, COORD_MIN);
		send_keypoint('0, '0);
		send_keypoint('1, coord_t'(1));
		settle_block();
	endtask

	// Largest window with one keypoint per frame; the median must order the
	// values as signed numbers across the whole range.
	task automatic test_full_window_signed();
		write_register(kwm_pkg::REG_WINDOW_SIZE, cfg_word_t'(MAXW));
		write_register(kwm_pkg::REG_KEYPOINTS_PER, cfg_word_t'(1));
		send_keypoint(COORD_MAX, COORD_MIN);
		send_keypoint(COORD_MIN, COORD_MAX);
		send_keypoint('1, coord_t'(1));
		send_keypoint('0, '0);
		send_keypoint(coord_t'(1), '1);
		send_keypoint(COORD_MAX, COORD_MAX);
		send_keypoint(COORD_MIN, COORD_MIN);
		send_keypoint(coord_t'(-2), coord_t'(2));
		send_keypoint(coord_t'(2), coord_t'(-2));
		settle_block();
	endtask

	// Data bits above the window field are dropped, and a keypoint count of
	// zero acts as one keypoint per frame.
	task automatic test_register_masking();
		write_register(kwm_pkg::REG_WINDOW_SIZE, cfg_word_t'(6'b101_010));
		write_register(kwm_pkg::REG_KEYPOINTS_PER, cfg_word_t'(0));
		send_keypoint(coord_t'(100), coord_t'(-100));
		send_keypoint(coord_t'(-50), coord_t'(50));
		send_keypoint(coord_t'(7), coord_t'(7));
		settle_block();
	endtask

	// Writes to indexes past the register list must not restart the frame:
	// the keypoint after them is still the second of its frame.
	task automatic test_unused_index();
		write_register(kwm_pkg::REG_WINDOW_SIZE, cfg_word_t'(2));
		write_register(kwm_pkg::REG_KEYPOINTS_PER, cfg_word_t'(2));
		send_keypoint(coord_t'(10), coord_t'(20));
		settle_block();
		write_register(REG_SPARE_A, '1);
		write_register(REG_SPARE_B, '1);
		send_keypoint(coord_t'(30), coord_t'(40));
		send_keypoint(coord_t'(-10), coord_t'(25));
		send_keypoint(coord_t'(35), coord_t'(-40));
		send_keypoint(coord_t'(5), coord_t'(5));
		send_keypoint(coord_t'(-35), coord_t'(45));
		settle_block();
	endtask

	// Random traffic under one idle pattern. The first batch uses the given
	// register values; later ones draw new settings. Each batch runs enough
	// frames to fill the window and then some, and usually stops mid-frame so
	// the next register write restarts a partial frame.
	task automatic run_random_phase(input int target, input int idle_pct, input int stall,
			input cfg_word_t win_data, input cfg_word_t kpf_data);
		int sent;
		int frames;
		int count;
		int k;
		int i;
		send_idle_pct = idle_pct;
		stall_pct <= stall;
		write_register(kwm_pkg::REG_WINDOW_SIZE, win_data);
		write_register(kwm_pkg::REG_KEYPOINTS_PER, kpf_data);
		sent = 0;
		while (sent < target) begin
			if (sent != 0) begin
				case ($urandom_range(3))
					0: write_register(kwm_pkg::REG_WINDOW_SIZE,
						cfg_word_t'($urandom_range(63)));
					1: write_register(kwm_pkg::REG_KEYPOINTS_PER, random_count_data());
					default: begin
						write_register(kwm_pkg::REG_WINDOW_SIZE,
							cfg_word_t'($urandom_range(63)));
						write_register(kwm_pkg::REG_KEYPOINTS_PER, random_count_data());
					end
				endcase
			end
			k = frame_keypoints();
			frames = window_frames() + int'($urandom_range(2));
			count = frames * k + int'($urandom_range(k - 1));
			for (i = 0; i < count; i++)
				send_keypoint(random_coord(), random_coord());
			sent += count;
			settle_block();
		end
	endtask

	// Result checking and the hang watchdog. Both work at the falling edge,
	// where every handshake signal is stable ahead of the rising edge that
	// completes the transfer.
	always @(negedge clk) begin
		smooth_item_t want;
		if (smooth_valid && !smooth_stall) begin
			if (pending_smooth.size() == 0) begin
				fault_count++;
				if (fault_count <= REPORT_LIMIT)
					$display("unexpected result transfer: x=%0d y=%0d last=%0b filtered=%0b",
						smooth_x, smooth_y, frame_last, filtered);
			end else begin
				want = pending_smooth.pop_front();
				if (smooth_x !== want.x || smooth_y !== want.y ||
						frame_last !== want.last || filtered !== want.filt) begin
					fault_count++;
					if (fault_count <= REPORT_LIMIT)
						$display("result mismatch: expected x=%0d y=%0d last=%0b filtered=%0b, got x=%0d y=%0d last=%0b filtered=%0b",
							want.x, want.y, want.last, want.filt,
							smooth_x, smooth_y, frame_last, filtered);
				end
			end
		end
		if ((coord_valid && !coord_stall) || (smooth_valid && !smooth_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("keypoint_window_median_core_test failed");
				$finish;
			end
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Phase one: slow receiver. The reset settings are checked first,
		// before any register write, then the directed cases.
		test_reset_values();
		test_window_one_extremes();
		test_full_window_signed();
		test_register_masking();
		test_unused_index();
		run_random_phase(520, 12, 86, cfg_word_t'(0), cfg_word_t'(1));

		// Phase two: slow sender, largest window and a clamped frame size.
		run_random_phase(520, 86, 12, cfg_word_t'(MAXW), cfg_word_t'(63));

		// Phase three: no idling on either side, one-frame window over the
		// largest frame.
		run_random_phase(520, 0, 0, cfg_word_t'(1), cfg_word_t'(MAXK));

		settle_block();
		repeat (MAXW + 4) @(posedge clk);
		if (pending_smooth.size() != 0)
			fault_count++;
		if (fault_count == 0)
			$display("keypoint_window_median_core_test passed");
		else
			$display("keypoint_window_median_core_test failed");
		$finish;
	end

endmodule
